>>> src/decimal_to_seven_segment_digits_unit_defines.svh
// Assertion macros for the RTL files; dssd_ser uses them.
`ifndef DECIMAL_TO_SEVEN_SEGMENT_DIGITS_UNIT_DEFINES_SVH
`define DECIMAL_TO_SEVEN_SEGMENT_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dssd_pkg.sv
package dssd_pkg;

    localparam int DIGITS   = 5;
    localparam int VALUE_W  = 31;
    localparam int REG_W    = 3;
    localparam int SEG_W    = 8;
    localparam int DIGIT_W  = 4;
    localparam int CNT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // x / 10 == (x * RECIP_10) >> RECIP_SH for every 32-bit x
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;
    localparam int          PROD_W   = VALUE_W + 32;

    typedef logic [DIGITS-1:0][SEG_W-1:0] pattern_row_t;

    typedef struct packed {
        logic [VALUE_W-1:0] rest;
        pattern_row_t       patterns;
    } stage_t;

    // Segment order: dot a b c d e f g, dot always dark
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 8'b0111_1110;
            4'd1:    p = 8'b0011_0000;
            4'd2:    p = 8'b0110_1101;
            4'd3:    p = 8'b0111_1001;
            4'd4:    p = 8'b0011_0011;
            4'd5:    p = 8'b0101_1011;
            4'd6:    p = 8'b0101_1111;
            4'd7:    p = 8'b0111_0000;
            4'd8:    p = 8'b0111_1111;
            4'd9:    p = 8'b0111_0011;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

>>> src/dssd_in_if.sv
interface dssd_in_if;
    import dssd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> src/dssd_out_if.sv
interface dssd_out_if;
    import dssd_pkg::*;

    logic             valid;
    logic             ready;
    logic [REG_W-1:0] digit_register;
    logic [SEG_W-1:0] segment_pattern;
    logic             last_write;

    modport source (output valid, output digit_register, output segment_pattern,
                    output last_write, input ready);
    modport sink   (input valid, input digit_register, input segment_pattern,
                    input last_write, output ready);
endinterface

>>> src/dssd_cell.sv
module dssd_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [dssd_pkg::CNT_W-1:0] slot,
    input  logic                       prev_valid,
    input  dssd_pkg::stage_t           prev_stage,
    output logic                       cell_valid,
    output dssd_pkg::stage_t           cell_stage
);
    import dssd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] diff;
    logic [DIGIT_W-1:0] digit;

    // Peel off one decimal digit: quotient by reciprocal, remainder by shift-add
    always_comb
    begin
        prod  = PROD_W'(prev_stage.rest) * PROD_W'(RECIP_10);
        quot  = VALUE_W'(prod[PROD_W-1:RECIP_SH]);
        diff  = prev_stage.rest - ((quot << 3) + (quot << 1));
        digit = diff[DIGIT_W-1:0];

        stage_next                = prev_stage;
        stage_next.rest           = quot;
        stage_next.patterns[slot] = seg_pattern(digit);
        valid_next                = advance ? prev_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_stage = stage_reg;

endmodule

>>> src/dssd_ser.sv
`include "decimal_to_seven_segment_digits_unit_defines.svh"

module dssd_ser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tail_valid,
    input  dssd_pkg::stage_t     tail_stage,
    output logic                 take,
    dssd_out_if.source           out
);
    import dssd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    pattern_row_t       pats_reg;
    logic               last;
    logic               fire;
    logic               load;

    assign last = (cnt_reg == CNT_W'(DIGITS - 1));
    assign fire = valid_reg && out.ready;
    assign take = !valid_reg || (fire && last);
    assign load = take && tail_valid;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pats_reg <= tail_stage.patterns;
        end
    end

    assign out.valid           = valid_reg;
    assign out.digit_register  = REG_W'(cnt_reg) + REG_W'(1);
    assign out.segment_pattern = pats_reg[cnt_reg];
    assign out.last_write      = last;

    `DSSD_ASSERT_NEXT(a_step_digit, fire && !last,
        out.valid && (out.digit_register == $past(out.digit_register) + REG_W'(1)),
        "digit register did not step after a non-final word")
    `DSSD_ASSERT_NEXT(a_restart_units, fire && last,
        !out.valid || (out.digit_register == REG_W'(1)),
        "new number did not start at the units digit")
    `DSSD_ASSERT_NOW(a_busy_hold, !take, out.valid && !(out.ready && out.last_write),
        "chain stalled while the output stage could take a number")

endmodule

>>> src/decimal_to_seven_segment_digits_unit.sv
// Channel | Dir | Word                                             | Per number
// --------+-----+--------------------------------------------------+-----------
// din     | in  | value[30:0]                                      | 1 word
// dout    | out | digit_register[2:0] segment_pattern[7:0] last_write | DIGITS words
//
// A number walks a chain of DIGITS cells, one cell per cycle while the chain
// shifts, each stripping one decimal digit, and then enters the output stage.
// That stage sends one word per cycle while dout is ready, units digit first,
// and loads the next number as its last word is taken. The chain shifts while
// its tail is empty or the output stage takes it; a number waiting at the tail
// otherwise freezes it. Reset clears only the valid flags and the word counter.

module decimal_to_seven_segment_digits_unit (
    input  logic       clk,
    input  logic       rst_n,
    dssd_in_if.sink    din,
    dssd_out_if.source dout
);
    import dssd_pkg::*;

    logic [DIGITS:0] chain_valid;
    stage_t          chain_stage [DIGITS+1];
    logic            take;
    logic            advance;

    // Shift the chain when the tail is empty or the output stage takes it
    assign advance   = take || !chain_valid[DIGITS];
    assign din.ready = advance;

    // Head of the chain: the raw number, no digits yet
    assign chain_valid[0]          = din.valid;
    assign chain_stage[0].rest     = din.value;
    assign chain_stage[0].patterns = '0;

    for (genvar k = 0; k < DIGITS; k++)
    begin : g_cell
        dssd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .slot       (CNT_W'(k)),
            .prev_valid (chain_valid[k]),
            .prev_stage (chain_stage[k]),
            .cell_valid (chain_valid[k+1]),
            .cell_stage (chain_stage[k+1])
        );
    end

    // Hold the finished digits and hand them out one word per cycle while dout is ready
    dssd_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (chain_valid[DIGITS]),
        .tail_stage (chain_stage[DIGITS]),
        .take       (take),
        .out        (dout)
    );

endmodule

>>> tb/decimal_to_seven_segment_digits_unit_tb.sv
`timescale 1ns / 1ps

module decimal_to_seven_segment_digits_unit_tb;
    import dssd_pkg::*;

    // Quiet cycles with no word moving on either side before giving up.
    // The worst legal quiet stretch is a sender gap overlapping a receiver
    // stall plus the pipeline depth, so this is generous.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles to hang around after the last expected write, so that a stray
    // extra write still has time to show up.
    localparam int TAIL_CYCLES  = 4 * DIGITS + 20;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        logic [REG_W-1:0] addr;
        logic [SEG_W-1:0] pattern;
        logic             last;
    } digit_write_t;

    typedef struct {
        logic [VALUE_W-1:0] number;
        bit                 drain_first; // hold until every write so far has come back
    } pending_number_t;

    logic clk;
    logic rst_n;

    dssd_in_if  in_ch ();
    dssd_out_if out_ch ();

    decimal_to_seven_segment_digits_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    pending_number_t pending_numbers[$];
    digit_write_t    expected_writes[$];

    int numbers_total;
    int numbers_taken;
    int writes_due;      // digit writes owed for every number taken so far
    int writes_seen;     // digit writes received so far
    int mismatch_count;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_span;
    int quiet_cycles;

    // Keep every input known from time zero, before the first edge.
    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Split a number into its low decimal digits, units first, and queue the
    // display write each digit should produce. Higher digits simply fall off.
    task automatic queue_digit_writes(input logic [VALUE_W-1:0] number);
        int unsigned  rest;
        int unsigned  digit;
        digit_write_t w;
        rest = 32'(number);
        for (int k = 0; k < DIGITS; k++)
        begin
            digit = rest % 10;
            rest  = rest / 10;
            w.addr = REG_W'(k + 1);
            case (digit)
                0: w.pattern = 8'h7E;
                1: w.pattern = 8'h30;
                2: w.pattern = 8'h6D;
                3: w.pattern = 8'h79;
                4: w.pattern = 8'h33;
                5: w.pattern = 8'h5B;
                6: w.pattern = 8'h5F;
                7: w.pattern = 8'h70;
                8: w.pattern = 8'h7F;
                default: w.pattern = 8'h73;
            endcase
            w.last = (k == DIGITS - 1);
            expected_writes.push_back(w);
        end
    endtask

    task automatic add_number(input logic [VALUE_W-1:0] number, input bit drain_first);
        pending_number_t p;
        p.number      = number;
        p.drain_first = drain_first;
        pending_numbers.push_back(p);
    endtask

    // Random numbers of mixed magnitude: the full word exercises every bit and
    // the dropped upper digits, the in-range band shows all five digits, and
    // the small ones lean on zero-filled upper digits.
    function automatic logic [VALUE_W-1:0] random_number();
        logic [VALUE_W-1:0] n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = VALUE_W'($urandom);
            4, 5, 6:    n = VALUE_W'($urandom_range(0, 99999));
            7:          n = VALUE_W'($urandom_range(0, 999));
            8:          n = VALUE_W'($urandom_range(1, 21000) * 100000
                              + $urandom_range(0, 9));
            default:    n = VALUE_W'({$urandom_range(0, 9), $urandom_range(0, 9)});
        endcase
        return n;
    endfunction

    // Sender: present words from the pending queue in bursts of random
    // length with random gaps, and hold a word steady until it is taken.
    // A number flagged drain_first waits for the output side to catch up.
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic            fire;
        pending_number_t head;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            numbers_taken <= 0;
            writes_due    <= 0;
            burst_left    <= 1;
            gap_left      <= 0;
        end
        else
        begin
            fire = in_ch.valid && in_ch.ready;
            if (fire)
            begin
                queue_digit_writes(in_ch.value);
                numbers_taken <= numbers_taken + 1;
                writes_due    <= writes_due + DIGITS;
            end

            if (in_ch.valid && !fire)
            begin
                // hold: the word is still waiting for ready
            end
            else if (gap_left != 0)
            begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_numbers.size() == 0)
            begin
                in_ch.valid <= 1'b0;
            end
            else if (pending_numbers[0].drain_first && (fire || writes_due != writes_seen))
            begin
                // drain: let every outstanding write come back first
                in_ch.valid <= 1'b0;
            end
            else
            begin
                head = pending_numbers.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.value <= head.number;
                if (burst_left <= 1)
                begin
                    // Now and then a long burst with no gap after it.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left <= $urandom_range(20, 60);
                        gap_left   <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= $urandom_range(1, 15);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: check every accepted write against the oldest expected one,
    // and drive ready from a stall pattern that switches mode every so often.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        digit_write_t want;
        logic         next_ready;
        if (!rst_n)
        begin
            out_ch.ready   <= 1'b0;
            writes_seen    <= 0;
            mismatch_count <= 0;
            stall_mode     <= 0;
            stall_span     <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                writes_seen <= writes_seen + 1;
                if (expected_writes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected write: addr %0d pattern %02h last %0b",
                                 out_ch.digit_register, out_ch.segment_pattern,
                                 out_ch.last_write);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (out_ch.digit_register !== want.addr ||
                        out_ch.segment_pattern !== want.pattern ||
                        out_ch.last_write !== want.last)
                    begin
                        if (mismatch_count < 10)
                            $display("write %0d: expected %0d/%02h/%0b got %0d/%02h/%0b",
                                     writes_seen, want.addr, want.pattern, want.last,
                                     out_ch.digit_register, out_ch.segment_pattern,
                                     out_ch.last_write);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            // Modes: 0 never stalls, 1 coin flip, 2 mostly stalled, 3 periodic.
            case (stall_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom_range(0, 1));
                2:       next_ready = ($urandom_range(0, 5) == 0);
                default: next_ready = (stall_span % 7) < 3;
            endcase
            out_ch.ready <= next_ready;

            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(20, 80);
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
        end
    end

    // Watchdog: give up if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        quiet_cycles = 0;

        // Directed numbers: extremes, every digit, dropped upper digits,
        // zero-filled upper digits, alternating bit patterns.
        add_number(31'd0, 1'b0);
        add_number(31'd1, 1'b0);
        add_number(31'd9, 1'b0);
        add_number(31'd10, 1'b0);
        add_number(31'd12345, 1'b0);
        add_number(31'd67890, 1'b0);
        add_number(31'd99999, 1'b0);
        add_number(31'd100000, 1'b0);
        add_number(31'd100005, 1'b0);
        add_number(31'd123456, 1'b0);
        add_number(31'd10000, 1'b0);
        add_number(31'd99990, 1'b0);
        add_number(31'd1010101, 1'b0);
        add_number(31'd1234567890, 1'b0);
        add_number(31'd800000000, 1'b0);
        add_number(31'h4000_0000, 1'b0);
        add_number(31'h5555_5555, 1'b0);
        add_number(31'h2AAA_AAAA, 1'b0);
        add_number(31'h7FFF_FFFF, 1'b0);
        add_number(31'd5, 1'b0);

        // Random part; drain the pipeline first at its start and now and then.
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_number(random_number(), (i == 0) || ($urandom_range(0, 39) == 0));
        numbers_total = pending_numbers.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every number to be taken and every write to come back.
        while (numbers_taken < numbers_total || expected_writes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
